[rtl/bba_pkg.sv]
// Package for the buddy block allocator: sizes, status codes and request kinds.
// Used by bba_tree and buddy_block_allocator_core; depends on nothing else.
package bba_pkg;
  localparam int unsigned LEVELS_DEF       = 9;
  localparam int unsigned HEADER_BYTES_DEF = 16;
  localparam int unsigned ADDR_W           = 24;
  localparam int unsigned LOG2_W           = 5;
  localparam int unsigned TOTAL_W          = 9;
  localparam int unsigned CLASS_W          = 4;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned LOG2_MAX         = 16;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OOM     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic CFG_LOG2  = 1'b0;
  localparam logic CFG_TOTAL = 1'b1;

  // Free map port request, one access per cycle.
  typedef struct packed {
    logic        we;
    logic        wbit;
    logic [15:0] addr;
  } map_req_t;
endpackage

[rtl/bba_tree.sv]
// Free map store of the buddy allocator: one free bit per tree node.
// Depends on bba_pkg; one synchronous read/write port, registered read data.
module bba_tree
  import bba_pkg::*;
#(
  parameter int unsigned LEVELS = LEVELS_DEF,
  localparam int unsigned NW    = LEVELS
) (
  input  logic             clk,
  input  map_req_t         req,
  output logic             rbit
);
  localparam int unsigned NODES = 1 << LEVELS;
  logic mem [NODES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[NW-1:0]] <= req.wbit;
    end
    rbit <= mem[req.addr[NW-1:0]];
  end
endmodule

[rtl/buddy_block_allocator_core.sv]
// Top level of the buddy block allocator: sequencer, tag store and config.
// Depends on bba_pkg and bba_tree.
//
// One request is handled at a time. An allocate scans the free map in the
// class found from length plus header, lowest node first, each node read
// as an address state, then a state for the registered read data,
// moving to larger classes until a free node is found. It then clears
// that node and walks down to the needed class: for each class one write
// sets the upper half free, the next clears the lower half. The scan
// dominates: a worst case reads nearly all 2^LEVELS nodes. A free reads
// and clears the tag of the block, then one read plus one write a class
// while merging. After reset and after every configuration write a
// clearing pass rewrites the free map with the greedy carve and the
// 2^(LEVELS-1) tags with zero; no word is taken during it. The result
// sits in an output register; the next word is taken once it has gone.
module buddy_block_allocator_core
  import bba_pkg::*;
#(
  parameter int unsigned LEVELS       = LEVELS_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // req_type[0], length[24:1], address[48:25]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // address_out[23:0], status[25:24], class[29:26]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata
);
  localparam int unsigned NW     = LEVELS;
  localparam int unsigned BW     = LEVELS - 1;
  localparam int unsigned NODES  = 1 << LEVELS;
  localparam int unsigned MAXBLK = 1 << (LEVELS - 1);
  localparam int unsigned KW     = $clog2(LEVELS + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CLASS, S_SCAN, S_SCANW, S_SPLIT, S_FTAG, S_FTAGW,
    S_MRD, S_MRDW, S_MDONE, S_OUT
  } state_t;

  state_t state;
  logic [LOG2_W-1:0]  blog;
  logic [TOTAL_W-1:0] tblocks;

  // Tag store: class+1 per basic block, 0 when nothing starts there.
  logic [CLASS_W-1:0] tag_mem [MAXBLK];
  logic [CLASS_W-1:0] tag_rd;
  logic               tag_we;
  logic [BW-1:0]      tag_addr;
  logic [CLASS_W-1:0] tag_wd;

  map_req_t mreq;
  logic     mbit;

  logic [NW:0]       cnt;       // clearing sweep and scan index
  logic [KW-1:0]     kneed, kcur;
  logic [BW:0]       blk;
  logic [BW:0]       carve_left, carve_at;
  logic [ADDR_W-1:0] req_len, req_addr;
  logic [ADDR_W-1:0] o_addr;
  logic [STATUS_W-1:0] o_st;
  logic [CLASS_W-1:0]  o_cls;

  // effective block size log2 and usable region
  logic [LOG2_W-1:0] lg;
  logic [BW+1:0]     cap;
  logic [ADDR_W:0]   fit;
  assign lg  = (blog > LOG2_W'(LOG2_MAX)) ? LOG2_W'(LOG2_MAX) : blog;
  assign fit = ADDR_W'(((ADDR_W+1)'(24'hFFFFFF - HEADER_BYTES)) >> lg) + 1'b1;
  always_comb begin
    logic [ADDR_W:0] c;
    c = (ADDR_W+1)'(tblocks);
    if (c > (ADDR_W+1)'(MAXBLK)) c = (ADDR_W+1)'(MAXBLK);
    if (c > fit) c = fit;
    cap = (BW+2)'(c);
  end

  function automatic logic [NW-1:0] node_of(input logic [KW-1:0] k, input logic [BW:0] b);
    logic [NW:0] base;
    base = ((NW+1)'(1) << (LEVELS - 1 - k)) - 1'b1;
    return NW'(base + (NW+1)'(b >> k));
  endfunction

  // carve: class chosen for the next free piece during the clear sweep
  logic [KW-1:0] ck;
  logic          ck_hit;
  always_comb begin
    ck = '0; ck_hit = 1'b0;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (!ck_hit && carve_left >= (BW+1)'(1 << k)) begin
        ck = KW'(k); ck_hit = 1'b1;
      end
    end
  end

  // needed class for the held length
  logic [KW-1:0] kn;
  logic          kn_ok;
  always_comb begin
    logic [ADDR_W+1:0] need;
    need  = (ADDR_W+2)'(req_len) + (ADDR_W+2)'(HEADER_BYTES);
    kn    = '0; kn_ok = 1'b0;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (lg + LOG2_W'(k) >= 26 || ((ADDR_W+2)'(1) << (lg + LOG2_W'(k))) >= need) begin
        kn = KW'(k); kn_ok = 1'b1;
      end
    end
  end

  logic [ADDR_W-1:0] foff;
  logic [ADDR_W-1:0] fblk;
  assign foff = req_addr - ADDR_W'(HEADER_BYTES);
  assign fblk = foff >> lg;

  always_comb begin
    mreq = '{we: 1'b0, wbit: 1'b0, addr: '0};
    tag_we = 1'b0; tag_addr = blk[BW-1:0]; tag_wd = '0;
    unique case (state)
      S_CLR: begin
        mreq.we = 1'b1; mreq.addr = 16'(cnt[NW-1:0]);
        mreq.wbit = ck_hit && (cnt[NW-1:0] == node_of(ck, carve_at));
        tag_we = !cnt[NW-1]; tag_addr = cnt[BW-1:0];
      end
      S_SCAN:  mreq.addr = 16'(node_of(kcur, cnt[BW:0] << kcur));
      S_SPLIT: begin
        // cnt[0] high: set the upper half free; low: clear the lower half
        mreq.we = 1'b1;
        mreq.addr = 16'(node_of(kcur, blk));
        if (kcur == kneed && !cnt[0]) begin
          tag_we = 1'b1; tag_wd = CLASS_W'(kneed) + 1'b1;
        end else begin
          mreq.wbit = cnt[0];
        end
      end
      S_FTAG:  tag_addr = fblk[BW-1:0];
      S_FTAGW: tag_we = (tag_rd != '0);
      S_MRD:   mreq.addr = 16'(node_of(kcur, blk ^ ((BW+1)'(1) << kcur)));
      S_MRDW: if (mbit) begin
        mreq.we = 1'b1; mreq.addr = 16'(node_of(kcur, blk ^ ((BW+1)'(1) << kcur)));
      end
      S_MDONE: begin
        mreq.we = 1'b1; mreq.wbit = 1'b1; mreq.addr = 16'(node_of(kcur, blk));
      end
      default: ;
    endcase
  end

  bba_tree #(.LEVELS(LEVELS)) u_tree (.clk(clk), .req(mreq), .rbit(mbit));

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_addr] <= tag_wd;
    tag_rd <= tag_mem[tag_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; cnt <= '0; blog <= LOG2_W'(7); tblocks <= TOTAL_W'(256);
      carve_left <= '0; carve_at <= '0; m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LOG2) blog <= cfg_wdata[LOG2_W-1:0];
        else tblocks <= cfg_wdata;
        state <= S_CLR; cnt <= '0;
      end
      if (state == S_CLR && cnt == '0 && !cfg_we) begin
        // first sweep cycle loads the carve; the node write this cycle
        // is redone since the low bits of cnt stay 0
        carve_left <= (BW+1)'(cap); carve_at <= '0;
        cnt <= (NW+1)'(1) << NW;
      end else if (!cfg_we) begin
        unique case (state)
          S_CLR: begin
            // counts up through all nodes; cnt top bit marks a live sweep
            if (ck_hit && cnt[NW-1:0] == node_of(ck, carve_at)) begin
              carve_at <= carve_at + ((BW+1)'(1) << ck);
              carve_left <= carve_left - ((BW+1)'(1) << ck);
            end
            if (cnt[NW-1:0] == NW'(NODES - 1)) state <= S_IDLE;
            else cnt <= {1'b1, cnt[NW-1:0] + 1'b1};
          end
          S_IDLE: if (s_tvalid) begin
            req_len <= s_tdata[24:1];
            req_addr <= s_tdata[48:25];
            state <= (s_tdata[0] == REQ_FREE) ? S_FTAG : S_CLASS;
          end
          S_CLASS: begin
            o_addr <= '0; o_cls <= '0;
            if (!kn_ok || ((BW+2)'(1) << kn) > cap) begin
              o_st <= ST_TOO_BIG; state <= S_OUT;
            end else begin
              kneed <= kn; kcur <= kn; cnt <= '0; state <= S_SCAN;
            end
          end
          S_SCAN: state <= S_SCANW;
          S_SCANW: begin
            if (mbit) begin
              blk <= (BW+1)'(cnt[BW:0] << kcur); cnt <= '0; state <= S_SPLIT;
            end else if ((cnt[BW:0] + 1'b1) == ((BW+1)'(1) << (LEVELS - 1 - kcur))) begin
              if (kcur == KW'(LEVELS - 1)) begin
                o_st <= ST_OOM; state <= S_OUT;
              end else begin
                kcur <= kcur + 1'b1; cnt <= '0; state <= S_SCAN;
              end
            end else begin
              cnt <= cnt + 1'b1; state <= S_SCAN;
            end
          end
          S_SPLIT: begin
            // cnt[0]=0: clear the taken node; then set upper halves
            if (kcur == kneed && cnt[0] == 1'b0) begin
              o_st <= ST_OK; o_cls <= CLASS_W'(kneed);
              o_addr <= ADDR_W'((ADDR_W)'(blk) << lg) + ADDR_W'(HEADER_BYTES);
              state <= S_OUT;
            end else if (cnt[0] == 1'b0) begin
              kcur <= kcur - 1'b1; blk <= blk + ((BW+1)'(1) << (kcur - 1'b1));
              cnt[0] <= 1'b1;
            end else begin
              blk <= blk - ((BW+1)'(1) << kcur);
              cnt[0] <= 1'b0;
            end
          end
          S_FTAG: begin
            o_addr <= '0; o_cls <= '0; o_st <= ST_BADFREE;
            blk <= (BW+1)'(fblk);
            if (req_addr < ADDR_W'(HEADER_BYTES) ||
                (foff & ((ADDR_W'(1) << lg) - 1'b1)) != '0 ||
                fblk >= ADDR_W'(cap)) state <= S_OUT;
            else state <= S_FTAGW;
          end
          S_FTAGW: begin
            if (tag_rd == '0) state <= S_OUT;
            else begin
              kcur <= (tag_rd - 1'b1 > CLASS_W'(LEVELS - 1)) ? KW'(LEVELS - 1)
                                                               : KW'(tag_rd - 1'b1);
              o_cls <= (tag_rd - 1'b1 > CLASS_W'(LEVELS - 1)) ? CLASS_W'(LEVELS - 1)
                                                                : tag_rd - 1'b1;
              o_addr <= req_addr; o_st <= ST_OK;
              state <= (tag_rd - 1'b1 >= CLASS_W'(LEVELS - 1)) ? S_MDONE : S_MRD;
            end
          end
          S_MRD: state <= S_MRDW;
          S_MRDW: begin
            if (mbit) begin
              blk <= blk & ~((BW+1)'(1) << kcur);
              kcur <= kcur + 1'b1;
              state <= (kcur + 1'b1 == KW'(LEVELS - 1)) ? S_MDONE : S_MRD;
            end else state <= S_MDONE;
          end
          S_MDONE: state <= S_OUT;
          S_OUT: begin
            m_tvalid <= 1'b1;
            if (m_tvalid && m_tready) begin
              m_tvalid <= 1'b0; state <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  assign s_tready = (state == S_IDLE) && !cfg_we;
  assign m_tdata  = {2'b00, o_cls, o_st, o_addr};

  // the tag of a freed block is cleared at its start while blk still holds
  // it, before merging moves blk down to the merged block

  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken with result pending");
  a_clr: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !m_tvalid) else $error("result during clear");
  a_ok_cls: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_st != ST_OK) |-> (o_cls == '0 && o_addr == '0))
    else $error("error result carries data");
endmodule

[test/buddy_block_allocator_core_tb.sv]
// Testbench for buddy_block_allocator_core: drives allocate and free words
// and checks every result against a predictor of the buddy tree built in here.
// Depends on bba_pkg and the RTL of the allocator; reads no files.
module buddy_block_allocator_core_tb;
  import bba_pkg::*;

  localparam int unsigned NLEV   = LEVELS_DEF;
  localparam int unsigned HDR    = HEADER_BYTES_DEF;
  localparam int unsigned MAXBLK = 1 << (NLEV - 1);
  localparam int unsigned NODES  = 1 << NLEV;
  localparam int unsigned AMASK  = 24'hFFFFFF;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [STATUS_W-1:0] status;
    logic [CLASS_W-1:0]  cls;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // req_type[0], length[24:1], address[48:25]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // address_out[23:0], status[25:24], class[29:26]
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_wdata = '0;

  // predictor state: configuration, free bit per tree node, class tag per block
  logic [LOG2_W-1:0]  mdl_log2;
  logic [TOTAL_W-1:0] mdl_total;
  logic               free_bit [NODES];
  logic [3:0]         class_tag [MAXBLK];

  grant_t      expected_grants[$];
  int unsigned live_addrs[$];     // data addresses currently allocated
  int unsigned last_freed;
  int          mismatches = 0;
  int          hold_cycles = 0;   // long receiver hold-off requested by a test

  buddy_block_allocator_core dut (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor of the buddy tree
  // ---------------------------------------------------------------------
  function automatic int unsigned eff_log2();
    return (mdl_log2 > LOG2_MAX) ? LOG2_MAX : mdl_log2;
  endfunction

  function automatic int unsigned usable_blocks();
    int unsigned cap, fit;
    cap = mdl_total;
    fit = ((AMASK - HDR) >> eff_log2()) + 1;
    if (cap > MAXBLK) cap = MAXBLK;
    if (cap > fit) cap = fit;
    return cap;
  endfunction

  function automatic int unsigned node_of(int unsigned k, int unsigned blk);
    return (((1 << (NLEV - 1 - k)) - 1) + (blk >> k)) & (NODES - 1);
  endfunction

  // Re-carve the whole region greedily, largest class first.
  function automatic void recarve();
    int unsigned left, at;
    left = usable_blocks();
    at = 0;
    foreach (free_bit[i]) free_bit[i] = 1'b0;
    foreach (class_tag[i]) class_tag[i] = '0;
    for (int k = NLEV - 1; k >= 0; k--)
      while (left >= (1 << k)) begin
        free_bit[node_of(k, at)] = 1'b1;
        at += 1 << k;
        left -= 1 << k;
      end
    live_addrs.delete();
  endfunction

  function automatic int lowest_free_block(int unsigned k);
    for (int unsigned i = 0; i < (1 << (NLEV - 1 - k)); i++)
      if (free_bit[node_of(k, i << k)]) return i << k;
    return -1;
  endfunction

  function automatic grant_t predict_alloc(logic [23:0] length);
    longint unsigned need;
    int unsigned lg, k, j;
    int blk;
    grant_t g;
    g = '0;
    need = longint'(length) + HDR;
    lg = eff_log2();
    for (k = 0; k < NLEV; k++)
      if ((64'd1 << (lg + k)) >= need) break;
    if (k >= NLEV || (1 << k) > usable_blocks()) begin
      g.status = ST_TOO_BIG;
      return g;
    end
    blk = -1;
    for (j = k; j < NLEV; j++) begin
      blk = lowest_free_block(j);
      if (blk >= 0) break;
    end
    if (blk < 0) begin
      g.status = ST_OOM;
      return g;
    end
    // take the block, hand the upper halves back while splitting down
    free_bit[node_of(j, blk)] = 1'b0;
    while (j > k) begin
      j--;
      free_bit[node_of(j, blk + (1 << j))] = 1'b1;
    end
    class_tag[blk] = 4'(k + 1);
    g.addr = ADDR_W'(((blk << lg) + HDR) & AMASK);
    g.cls = CLASS_W'(k);
    g.status = ST_OK;
    live_addrs.push_back(32'(g.addr));
    return g;
  endfunction

  function automatic grant_t predict_free(logic [23:0] addr);
    int unsigned lg, off, blk, k, bud;
    grant_t g;
    g = '0;
    g.status = ST_BADFREE;
    lg = eff_log2();
    if (addr < HDR) return g;
    off = addr - HDR;
    if ((off & ((1 << lg) - 1)) != 0) return g;
    blk = off >> lg;
    if (blk >= usable_blocks() || class_tag[blk] == 0) return g;
    k = class_tag[blk] - 1;
    if (k > NLEV - 1) k = NLEV - 1;
    g.cls = CLASS_W'(k);
    class_tag[blk] = '0;
    // merge upward while the buddy of equal size is free
    while (k < NLEV - 1) begin
      bud = blk ^ (1 << k);
      if (bud >= MAXBLK || !free_bit[node_of(k, bud)]) break;
      free_bit[node_of(k, bud)] = 1'b0;
      blk &= ~(1 << k);
      k++;
    end
    free_bit[node_of(k, blk)] = 1'b1;
    g.addr = addr;
    g.status = ST_OK;
    foreach (live_addrs[i])
      if (live_addrs[i] == addr) begin
        live_addrs.delete(i);
        break;
      end
    last_freed = 32'(addr);
    return g;
  endfunction

  // ---------------------------------------------------------------------
  // Sender, receiver and result check
  // ---------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one word from a falling edge; predict its result once taken.
  task automatic send_word(logic req, logic [23:0] length, logic [23:0] addr);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, addr, length, req};
    do @(posedge clk); while (!s_tready);
    if (req == REQ_ALLOC) expected_grants.push_back(predict_alloc(length));
    else expected_grants.push_back(predict_free(addr));
    @(negedge clk);
  endtask

  // Drop valid and wait until every grant has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    wait (expected_grants.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [8:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LOG2) mdl_log2 = value[LOG2_W-1:0];
    else mdl_total = value;
    recarve();
  endtask

  // Receiver: runs of readiness, short stalls, the odd long one, and any
  // long hold-off that a test asks for.
  always @(negedge clk) begin : rx_ready
    int run;
    int r;
    if (rst) begin
      m_tready <= 1'b0;
      run = 0;
    end else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles--;
    end else if (run > 0) begin
      run--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        m_tready <= 1'b1;
        run = $urandom_range(0, 30);
      end else if (r < 90) begin
        m_tready <= 1'b0;
        run = $urandom_range(0, 2);
      end else begin
        m_tready <= 1'b0;
        run = $urandom_range(10, 50);
      end
    end
  end

  always @(posedge clk) begin : grant_check
    grant_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.addr = m_tdata[23:0];
      got.status = m_tdata[25:24];
      got.cls = m_tdata[29:26];
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %h", m_tdata);
      end else begin
        want = expected_grants.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp addr %h st %0d cls %0d, got addr %h st %0d cls %0d",
                     want.addr, want.status, want.cls, got.addr, got.status, got.cls);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  // Length that lands in class k for the present block size.
  function automatic logic [23:0] length_for_class(int unsigned k);
    longint lo, hi;
    hi = (64'd1 << (eff_log2() + k)) - HDR;
    lo = (k == 0) ? 0 : (64'd1 << (eff_log2() + k - 1)) - HDR + 1;
    if (hi > AMASK) hi = AMASK;
    if (lo < 0) lo = 0;
    if (hi < lo) return hi < 0 ? 24'd0 : 24'(hi);
    return 24'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
  endfunction

  // One random word: mostly well-formed allocs and frees of live blocks,
  // the rest double frees and raw noise.
  task automatic random_word();
    int r;
    int unsigned k;
    r = $urandom_range(0, 99);
    k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NLEV - 1) : $urandom_range(0, 3);
    if (r < 50 || (r < 85 && live_addrs.size() == 0))
      send_word(REQ_ALLOC, length_for_class(k), 24'($urandom));
    else if (r < 85)
      send_word(REQ_FREE, 24'($urandom),
                24'(live_addrs[$urandom_range(0, live_addrs.size() - 1)]));
    else if (r < 89)
      send_word(REQ_FREE, 24'($urandom), 24'(last_freed));
    else if (r < 95)
      send_word(REQ_FREE, 24'($urandom), 24'($urandom));
    else
      send_word(REQ_ALLOC, 24'($urandom), 24'($urandom));
  endtask

  task automatic test_directed_defaults();
    send_word(REQ_ALLOC, 24'd0, 24'd0);             // smallest class
    send_word(REQ_ALLOC, 24'hFFFFFF, 24'hFFFFFF);   // far too large
    send_word(REQ_ALLOC, 24'd32752, 24'd0);         // whole region, now split
    send_word(REQ_ALLOC, 24'd32753, 24'd0);         // one byte past the top class
    send_word(REQ_ALLOC, 24'd112, 24'd0);           // exact fit of one block
    send_word(REQ_ALLOC, 24'd113, 24'd0);           // spills into class one
    send_word(REQ_FREE, 24'd0, 24'd0);              // below the header
    send_word(REQ_FREE, 24'd0, 24'd17);             // off a block boundary
    send_word(REQ_FREE, 24'd0, 24'd16 + 24'd128 * 5); // aligned, never granted
    send_word(REQ_FREE, 24'd0, 24'd16 + 24'd128 * 256); // beyond the region
    send_word(REQ_FREE, 24'd0, 24'd16);
    send_word(REQ_FREE, 24'd0, 24'd16);             // double free
    send_word(REQ_FREE, 24'd0, 24'd144);
    send_word(REQ_FREE, 24'd0, 24'd272);            // merges back to the full region
    send_word(REQ_ALLOC, 24'd32752, 24'd0);         // full region again
    send_word(REQ_ALLOC, 24'd0, 24'd0);             // out of memory
    send_word(REQ_FREE, 24'd0, 24'd16);
    drain();
  endtask

  task automatic test_config_extremes();
    logic [4:0] lg_set [6] = '{5'd4, 5'd16, 5'd0, 5'd31, 5'd3, 5'd7};
    logic [8:0] tot_set [6] = '{9'd1, 9'd0, 9'd511, 9'd3, 9'd100, 9'd256};
    foreach (lg_set[i]) begin
      write_reg(CFG_LOG2, 9'(lg_set[i]));
      write_reg(CFG_TOTAL, tot_set[i]);
      send_word(REQ_ALLOC, 24'd0, 24'd0);
      send_word(REQ_ALLOC, length_for_class(NLEV - 1), 24'd0);
      repeat (12) random_word();
      drain();
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 10; p++) begin
      write_reg(CFG_LOG2, 9'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                       : $urandom_range(4, 9)));
      write_reg(CFG_TOTAL, 9'($urandom_range(0, 4) == 0 ? $urandom_range(0, 511)
                                                        : $urandom_range(8, 256)));
      repeat (110) random_word();
      drain();
    end
  endtask

  // Hold the receiver off long enough that the block backs up and stalls input.
  task automatic test_backpressure();
    write_reg(CFG_LOG2, 9'd7);
    write_reg(CFG_TOTAL, 9'd256);
    hold_cycles = 400;
    repeat (30) random_word();
    drain();
  endtask

  initial begin
    mdl_log2 = 5'd7;
    mdl_total = 9'd256;
    recarve();
    last_freed = HDR;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_directed_defaults();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();
    drain();
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("status: fail");
    $finish;
  end
endmodule

[files.f]
rtl/bba_pkg.sv
rtl/bba_tree.sv
rtl/buddy_block_allocator_core.sv
test/buddy_block_allocator_core_tb.sv
